FILE: hw/rtl/stseg_pkg.sv
// Shared types and constants for the silence track segmenter.
`timescale 1ns / 1ps

package stseg_pkg;

   // Default build parameters
   localparam int DEF_INDEX_BITS  = 32;
   localparam int DEF_SAMPLE_BITS = 16;

   // Fixed field widths
   localparam int LEVEL_BITS = 16;
   localparam int RUN_BITS   = 24;
   localparam int TRACK_BITS = 32;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   // Register map (byte addresses)
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_QUIET_THRESHOLD   = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_SILENCE_RUN_LIMIT = 3'd4;

   // Register reset values: 0.001 of full scale, 3 s at 44.1 kHz
   localparam logic [LEVEL_BITS-1:0] RESET_QUIET_THRESHOLD   = 16'd33;
   localparam logic [RUN_BITS-1:0]   RESET_SILENCE_RUN_LIMIT = 24'd132300;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] quiet_threshold;
      logic [RUN_BITS-1:0]   silence_run_limit;
   } stseg_cfg_type;

endpackage

FILE: hw/rtl/stseg_csr.sv
// Configuration register block with an APB-style access port.
`timescale 1ns / 1ps

module stseg_csr
   import stseg_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output stseg_cfg_type            cfg
);

   logic [LEVEL_BITS-1:0] level_ff;
   logic [RUN_BITS-1:0]   limit_ff;
   logic                  wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= RESET_QUIET_THRESHOLD;
         limit_ff <= RESET_SILENCE_RUN_LIMIT;
      end else if (wr_en) begin
         unique case (csr_paddr)
            ADDR_QUIET_THRESHOLD:   level_ff <= csr_pwdata[LEVEL_BITS-1:0];
            ADDR_SILENCE_RUN_LIMIT: limit_ff <= csr_pwdata[RUN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         ADDR_QUIET_THRESHOLD:   csr_prdata = CSR_DATA_BITS'(level_ff);
         ADDR_SILENCE_RUN_LIMIT: csr_prdata = CSR_DATA_BITS'(limit_ff);
         default:                csr_prdata = '0;
      endcase
   end

   assign cfg.quiet_threshold   = level_ff;
   assign cfg.silence_run_limit = limit_ff;

endmodule

FILE: hw/rtl/stseg_core.sv
// Segmenter datapath: input register, track state update, result register.
`timescale 1ns / 1ps

module stseg_core
   import stseg_pkg::*;
#(
   parameter int INDEX_BITS  = DEF_INDEX_BITS,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  stseg_cfg_type                cfg,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_right_sample,
   input  logic                         req_last_of_stream,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [TRACK_BITS-1:0]        rsp_track_first_index,
   output logic [TRACK_BITS-1:0]        rsp_track_last_index
);

   localparam int MAG_BITS = SAMPLE_BITS + 1;
   localparam int CMP_BITS = (MAG_BITS > LEVEL_BITS) ? MAG_BITS : LEVEL_BITS;
   localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;

   // input register
   logic                          in_valid_ff, in_valid_in;
   logic signed [SAMPLE_BITS-1:0] left_ff, right_ff;
   logic                          last_ff;

   // track state
   logic [INDEX_BITS-1:0] pair_index_ff, pair_index_in;
   logic                  inside_ff, inside_in;
   logic [RUN_BITS-1:0]   quiet_ff, quiet_in;
   logic [INDEX_BITS-1:0] start_ff, start_in;
   logic [INDEX_BITS-1:0] loud_ff, loud_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic [INDEX_BITS-1:0] out_first_ff, out_last_ff;
   logic [INDEX_BITS-1:0] emit_first, emit_last;

   logic                  advance, emit, silent;
   logic [CMP_BITS-1:0]   mag_l, mag_r, level_x;
   logic [RUN_BITS-1:0]   limit, quiet_inc;

   function automatic logic [CMP_BITS-1:0] magnitude(logic signed [SAMPLE_BITS-1:0] s);
      logic signed [MAG_BITS-1:0] wide;
      wide = MAG_BITS'(s);
      if (wide < 0) begin
         wide = -wide;
      end
      return CMP_BITS'(unsigned'(wide));
   endfunction

   // stage one moves on when the result register is free or being emptied
   assign advance     = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign in_valid_in = req_valid ? 1'b1 : (in_valid_ff && !advance);

   assign mag_l   = magnitude(left_ff);
   assign mag_r   = magnitude(right_ff);
   assign level_x = CMP_BITS'(cfg.quiet_threshold);
   assign silent  = (mag_l <= level_x) && (mag_r <= level_x);
   assign limit   = (cfg.silence_run_limit == '0) ? RUN_BITS'(1) : cfg.silence_run_limit;
   assign quiet_inc = quiet_ff + RUN_BITS'(1);

   always_comb begin
      pair_index_in = pair_index_ff;
      inside_in     = inside_ff;
      quiet_in      = quiet_ff;
      start_in      = start_ff;
      loud_in       = loud_ff;
      emit          = 1'b0;
      emit_first    = start_ff;
      emit_last     = loud_ff;

      if (!inside_ff) begin
         if (!silent) begin
            inside_in = 1'b1;
            start_in  = pair_index_ff;
            loud_in   = pair_index_ff;
            quiet_in  = '0;
         end
      end else if (silent) begin
         quiet_in = quiet_inc;
         if (quiet_inc >= limit) begin
            emit      = 1'b1;
            inside_in = 1'b0;
            quiet_in  = '0;
         end
      end else begin
         quiet_in = '0;
         loud_in  = pair_index_ff;
      end

      // emitted indices come from the updated track bounds
      emit_first = start_in;
      emit_last  = loud_in;

      if (last_ff) begin
         if (inside_in) begin
            emit = 1'b1;
         end
         pair_index_in = '0;
         inside_in     = 1'b0;
         quiet_in      = '0;
         start_in      = '0;
         loud_in       = '0;
      end else if (pair_index_ff < IDX_MAX) begin
         pair_index_in = pair_index_ff + INDEX_BITS'(1);
      end
   end

   always_comb begin
      if (advance) begin
         out_valid_in = emit;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         pair_index_ff <= '0;
         inside_ff     <= 1'b0;
         quiet_ff      <= '0;
         start_ff      <= '0;
         loud_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            pair_index_ff <= pair_index_in;
            inside_ff     <= inside_in;
            quiet_ff      <= quiet_in;
            start_ff      <= start_in;
            loud_ff       <= loud_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         left_ff  <= req_left_sample;
         right_ff <= req_right_sample;
         last_ff  <= req_last_of_stream;
      end
      if (advance && emit) begin
         out_first_ff <= emit_first;
         out_last_ff  <= emit_last;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_track_first_index = TRACK_BITS'(out_first_ff);
   assign rsp_track_last_index  = TRACK_BITS'(out_last_ff);

endmodule

FILE: hw/rtl/silence_track_segmenter.sv
// Top level of the silence track segmenter: CSR block and datapath.
// Path: an accepted request transaction passes the input register, then the
//   result register, which drives response valid.
// Throughput: one sample pair per cycle while the response side takes results.
// Reset: synchronous, active high; clears the pipeline and track state and
//   loads quiet_threshold = 33 and silence_run_limit = 132300.
`timescale 1ns / 1ps

module silence_track_segmenter
   import stseg_pkg::*;
#(
   parameter int INDEX_BITS  = DEF_INDEX_BITS,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel: one stereo pair per transaction
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_right_sample,
   input  logic                          req_last_of_stream,
   // response channel: one transaction per closed track
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [TRACK_BITS-1:0]         rsp_track_first_index,
   output logic [TRACK_BITS-1:0]         rsp_track_last_index,
   // configuration port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]      csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]      csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                          csr_pready
);

   stseg_cfg_type cfg;

   // The user must write registers only while no transaction is in flight; the block does not enforce this.
   stseg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Datapath: silence test, run counter and track bounds in one pass,
   // with the result held until the response side takes it.
   stseg_core #(
      .INDEX_BITS  (INDEX_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_left_sample       (req_left_sample),
      .req_right_sample      (req_right_sample),
      .req_last_of_stream    (req_last_of_stream),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_track_first_index (rsp_track_first_index),
      .rsp_track_last_index  (rsp_track_last_index)
   );

endmodule
